// File: src/cubic_lattice_order_parameter_core_assert.svh
// assertion macros used by the checker file
`ifndef CUBIC_LATTICE_ORDER_PARAMETER_CORE_ASSERT_SVH
`define CUBIC_LATTICE_ORDER_PARAMETER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define CLOP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define CLOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/clop_pkg.sv
// types, constants and tables of the cubic lattice order parameter core
package clop_pkg;

  localparam int unsigned IterW = 6;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps = 33;

  localparam logic [31:0] CordicGain = 32'h26DD3B6A;

  // configuration register indexes
  localparam logic [1:0] REG_K_FCC = 2'd0;
  localparam logic [1:0] REG_K_BCC = 2'd1;
  localparam logic [1:0] REG_K_SC  = 2'd2;

  // lattice codes
  localparam logic [1:0] LAT_FCC = 2'd0;
  localparam logic [1:0] LAT_BCC = 2'd1;
  localparam logic [1:0] LAT_SC  = 2'd2;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               last_atom;
  } in_t;

  typedef struct packed {
    logic [15:0] corr_fcc;
    logic [15:0] corr_bcc;
    logic [15:0] corr_sc;
    logic [16:0] atoms_seen;
  } out_t;

  typedef struct packed {
    logic             take;
    logic             phase;
    logic             rot_load;
    logic             rot_step;
    logic             acc;
    logic             sq_c;
    logic             sq_s;
    logic             sqrt_step;
    logic             div_load;
    logic             div_step;
    logic             res_store;
    logic             publish;
    logic [IterW-1:0] iter;
    logic [1:0]       lat;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
  } sts_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_of(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: src/clop_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle while step_i is high
module clop_cordic (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               step_i,
  input  logic [4:0]         iter_i,
  input  logic [31:0]        angle_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [33:0] HalfTurn    = 34'sd2147483648;

  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic               flip_q, flip_d;
  logic signed [33:0] a, dx, dy, at;

  function automatic logic signed [15:0] q15_of(input logic signed [33:0] v,
                                                input logic flip);
    logic signed [33:0] r;
    logic signed [15:0] c;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      c = 16'sd32767;
    end else if (r < -34'sd32767) begin
      c = -16'sd32767;
    end else begin
      c = r[15:0];
    end
    return flip ? -c : c;
  endfunction

  always_comb begin
    a      = {{2{angle_i[31]}}, angle_i};
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    dx     = y_q >>> iter_i;
    dy     = x_q >>> iter_i;
    at     = $signed({2'b00, clop_pkg::atan_of(iter_i)});
    if (load_i) begin
      // fold into the right half plane
      flip_d = 1'b0;
      if (a > QuarterTurn) begin
        a      = a - HalfTurn;
        flip_d = 1'b1;
      end else if (a < -QuarterTurn) begin
        a      = a + HalfTurn;
        flip_d = 1'b1;
      end
      x_d = $signed({2'b00, clop_pkg::CordicGain});
      y_d = '0;
      z_d = a;
    end else if (step_i) begin
      if (!z_q[33]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign cos_o = q15_of(x_q, flip_q);
  assign sin_o = q15_of(y_q, flip_q);

endmodule

// File: src/clop_ctrl.sv
// sequencer: per-atom rotation and end-of-set magnitude and division passes
module clop_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  clop_pkg::sts_t  sts_i,
  output clop_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PHASE = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_ROT   = 4'd3;
  localparam logic [3:0] S_ACC   = 4'd4;
  localparam logic [3:0] S_SQC   = 4'd5;
  localparam logic [3:0] S_SQS   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DLOAD = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_STORE = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam int unsigned IW = clop_pkg::IterW;

  logic [3:0]    state_q, state_d;
  logic [IW-1:0] iter_q, iter_d;
  logic [1:0]    lat_q, lat_d;
  logic          out_valid_q, out_valid_d;
  logic          publish;

  assign publish = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    lat_d   = lat_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PHASE;
      end
      S_PHASE: begin
        if (sts_i.full) begin
          lat_d   = clop_pkg::LAT_FCC;
          state_d = sts_i.last ? S_SQC : S_IDLE;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        iter_d  = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(CORDIC_STEPS - 1)) state_d = S_ACC;
      end
      S_ACC: begin
        lat_d   = clop_pkg::LAT_FCC;
        state_d = sts_i.last ? S_SQC : S_IDLE;
      end
      S_SQC: begin
        state_d = S_SQS;
      end
      S_SQS: begin
        iter_d  = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(clop_pkg::SqrtSteps - 1)) state_d = S_DLOAD;
      end
      S_DLOAD: begin
        iter_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == IW'(clop_pkg::DivSteps - 1)) state_d = S_STORE;
      end
      S_STORE: begin
        if (lat_q == clop_pkg::LAT_SC) begin
          state_d = S_OUT;
        end else begin
          lat_d   = lat_q + 1'b1;
          state_d = S_SQC;
        end
      end
      S_OUT: begin
        if (publish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = publish || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      lat_q       <= clop_pkg::LAT_FCC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      lat_q       <= lat_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.phase     = (state_q == S_PHASE) && !sts_i.full;
    cmd_o.rot_load  = (state_q == S_LOAD);
    cmd_o.rot_step  = (state_q == S_ROT);
    cmd_o.acc       = (state_q == S_ACC);
    cmd_o.sq_c      = (state_q == S_SQC);
    cmd_o.sq_s      = (state_q == S_SQS);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    cmd_o.div_load  = (state_q == S_DLOAD);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.res_store = (state_q == S_STORE);
    cmd_o.publish   = publish;
    cmd_o.iter      = iter_q;
    cmd_o.lat       = lat_q;
  end

endmodule

// File: src/clop_dp.sv
// datapath: wave numbers, phases, cordics, accumulators, sqrt and divider
module clop_dp #(
  parameter int unsigned MAX_ATOMS = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i,
  input  clop_pkg::in_t   in_i,
  input  clop_pkg::cmd_t  cmd_i,
  output clop_pkg::sts_t  sts_o,
  output clop_pkg::out_t  out_o
);

  localparam int unsigned CW = $clog2(MAX_ATOMS + 1);

  logic [31:0]        k_q [3];
  clop_pkg::in_t      in_q;
  logic signed [25:0] pos [3];
  logic [31:0]        ph_q [3];
  logic signed [15:0] cq [3];
  logic signed [15:0] sq [3];
  logic signed [31:0] acc_c_q [3];
  logic signed [31:0] acc_s_q [3];
  logic [CW-1:0]      count_q;
  logic [63:0]        m2_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;
  logic [32:0]        num_q;
  logic [CW:0]        drem_q;
  logic [15:0]        res_q [3];
  clop_pkg::out_t     out_q;

  logic signed [31:0] sel;
  logic [32:0]        sel_abs;
  logic [63:0]        prod;
  logic [35:0]        sr, strial;
  logic [CW:0]        dt;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [15:0] v);
    logic signed [32:0] s;
    s = {a[31], a} + {{17{v[15]}}, v};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return s[31:0];
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q[0] <= '0;
      k_q[1] <= '0;
      k_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clop_pkg::REG_K_FCC: k_q[0] <= cfg_data_i;
        clop_pkg::REG_K_BCC: k_q[1] <= cfg_data_i;
        clop_pkg::REG_K_SC:  k_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) in_q <= in_i;
  end

  // coordinate combinations per lattice
  assign pos[0] = 26'(in_q.x) - 26'(in_q.y) + 26'(in_q.z);
  assign pos[1] = 26'(in_q.x) + 26'(in_q.z);
  assign pos[2] = 26'(in_q.x);

  for (genvar g = 0; g < 3; g++) begin : g_lat
    logic signed [58:0] p;
    assign p = pos[g] * $signed({1'b0, k_q[g]});
    always_ff @(posedge clk_i) begin
      if (cmd_i.phase) ph_q[g] <= p[39:8];
    end
    clop_cordic u_cordic (
      .clk_i   (clk_i),
      .load_i  (cmd_i.rot_load),
      .step_i  (cmd_i.rot_step),
      .iter_i  (cmd_i.iter[4:0]),
      .angle_i (ph_q[g]),
      .cos_o   (cq[g]),
      .sin_o   (sq[g])
    );
  end

  // accumulators and atom count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        acc_c_q[i] <= '0;
        acc_s_q[i] <= '0;
      end
      count_q <= '0;
    end else if (cmd_i.publish) begin
      for (int i = 0; i < 3; i++) begin
        acc_c_q[i] <= '0;
        acc_s_q[i] <= '0;
      end
      count_q <= '0;
    end else if (cmd_i.acc) begin
      for (int i = 0; i < 3; i++) begin
        acc_c_q[i] <= sat_add(acc_c_q[i], cq[i]);
        acc_s_q[i] <= sat_add(acc_s_q[i], sq[i]);
      end
      count_q <= count_q + 1'b1;
    end
  end

  assign sts_o.full = (count_q >= CW'(MAX_ATOMS));
  assign sts_o.last = in_q.last_atom;

  // squared magnitude, one multiplier shared by the cosine and sine sums
  assign sel     = cmd_i.sq_c ? acc_c_q[cmd_i.lat] : acc_s_q[cmd_i.lat];
  assign sel_abs = sel[31] ? -{sel[31], sel} : {sel[31], sel};
  assign prod    = sel_abs[31:0] * sel_abs[31:0];

  // digit-by-digit square root, two radicand bits per cycle
  assign sr     = {rem_q, m2_q[63:62]};
  assign strial = {2'b00, root_q, 2'b01};

  // restoring division, one quotient bit per cycle
  assign dt = {drem_q[CW-1:0], num_q[32]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_c) begin
      m2_q   <= prod;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sq_s) begin
      m2_q <= m2_q + prod;
    end else if (cmd_i.sqrt_step) begin
      m2_q <= {m2_q[61:0], 2'b00};
      if (sr >= strial) begin
        rem_q  <= 34'(sr - strial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= 34'(sr);
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.div_load) begin
      num_q  <= 33'(root_q) + 33'(count_q >> 1);
      drem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dt >= {1'b0, count_q}) begin
        drem_q <= dt - {1'b0, count_q};
        num_q  <= {num_q[31:0], 1'b1};
      end else begin
        drem_q <= dt;
        num_q  <= {num_q[31:0], 1'b0};
      end
    end
    if (cmd_i.res_store) begin
      res_q[cmd_i.lat] <= (num_q > 33'd32768) ? 16'h8000 : num_q[15:0];
    end
    if (cmd_i.publish) begin
      out_q.corr_fcc   <= res_q[0];
      out_q.corr_bcc   <= res_q[1];
      out_q.corr_sc    <= res_q[2];
      out_q.atoms_seen <= 17'(count_q);
    end
  end

  assign out_o = out_q;

endmodule

// File: src/cubic_lattice_order_parameter_core.sv
// top level of the cubic lattice order parameter core
//
// usage:
//   atom positions come in on the in channel (valid/ready), one item per atom,
//   with last_atom set on the final atom of a set. for that last item one
//   result item leaves on the out channel (valid/ready): |sum exp(i*phase)|
//   divided by the atom count for fcc, bcc and sc, plus the count itself.
//   the three wave numbers are written through cfg_we_i/cfg_idx_i/cfg_data_i
//   while the block is idle; writes take effect at once, no read-back.
// timing:
//   an atom occupies the core through the phase, load, rotation and accumulate
//   states: in_ready_o returns once the accumulate state is done, so a new atom
//   is not taken before the previous one is through. the three iterative cordic
//   units run side by side, one micro-rotation per cycle, and set the atom rate.
//   a last atom adds the end-of-set pass: per lattice the squaring of both sums,
//   32 square root steps, the division and one store, for fcc, bcc and sc in
//   turn, then the result moves into the output register.
//   atoms beyond MAX_ATOMS are taken but dropped without rotation or summing.
// reset: asynchronous, clears sums, count, wave numbers and out_valid_o.
// stall: the result waits in the output register while new atoms of the
//   next set are taken; only the next end of set waits for it to drain.
module cubic_lattice_order_parameter_core #(
  parameter int unsigned MAX_ATOMS    = 65536,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // atom items
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  clop_pkg::in_t  in_i,
  // result items
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output clop_pkg::out_t out_o,
  // wave number registers
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);

  clop_pkg::cmd_t cmd;
  clop_pkg::sts_t sts;

  // sequencer drives the datapath commands; wave number writes come from cfg_we_i
  clop_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // phases, cordics, sums and the shared sqrt/divide unit
  clop_dp #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule

// File: src/clop_checker.sv
// port-level checks of the core and their bind
`include "cubic_lattice_order_parameter_core_assert.svh"

module clop_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input clop_pkg::out_t out_o
);

  `CLOP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result item lost")

  `CLOP_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "ready after take")

  `CLOP_ASSERT_NOW(a_corr_range, out_valid_o, out_o.corr_fcc <= 16'd32768 && out_o.corr_bcc <= 16'd32768 && out_o.corr_sc <= 16'd32768, "order parameter above one")

endmodule

bind cubic_lattice_order_parameter_core clop_checker u_clop_checker (.*);
